>>> src/hdc_pkg.sv
package hdc_pkg;

  // default sizing, handed down from the top level
  localparam int DEF_CLASS_COUNT_MAX = 16;
  localparam int DEF_DIMENSION_MAX   = 4096;
  localparam int DEF_PROTO_WIDTH     = 24;

  // fixed field widths
  localparam int ELEM_W   = 16;
  localparam int OP_W     = 2;
  localparam int CLS_IN_W = 4;
  localparam int CFG_W    = 13;
  localparam int BEST_W   = 4;

  localparam logic [CFG_W-1:0] LEN_RST = 13'd4096;

  // opcodes, sampled on the first word of a vector
  localparam logic [OP_W-1:0] OP_TRAIN    = 2'd0;
  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

  typedef enum logic [2:0] {
    MUL_IDLE    = 3'd0,
    MUL_LOAD_SQ = 3'd1,
    MUL_LOAD_NM = 3'd2,
    MUL_STEP    = 3'd3,
    MUL_SAVE    = 3'd4
  } mul_op_e;

  typedef struct packed {
    logic    rd_en;
    logic    clr_wr;
    logic    tr_wr;
    logic    acc_clr;
    logic    mac_en;
    logic    arg_init;
    logic    best_upd;
    logic    sel_right;
    mul_op_e mul_op;
    logic    res_load;
    logic    res_none;
  } cmd_t;

  typedef struct packed {
    logic need_mul;
    logic beats;
    logic out_free;
  } sts_t;

  // signed dot accumulator width
  function automatic int f_dot_w(input int pw, input int dmax);
    return pw + ELEM_W + $clog2(dmax);
  endfunction

  // unsigned squared norm accumulator width
  function automatic int f_norm_w(input int pw, input int dmax);
    return 2 * pw + $clog2(dmax);
  endfunction

endpackage

>>> src/hdc_if.sv
interface hdc_in_if;
  logic                                valid;
  logic                                ready;
  logic [hdc_pkg::OP_W-1:0]            opcode;
  logic [hdc_pkg::CLS_IN_W-1:0]        class_index;
  logic signed [hdc_pkg::ELEM_W-1:0]   element_value;

  modport source (output valid, output opcode, output class_index, output element_value,
                  input ready);
  modport sink   (input valid, input opcode, input class_index, input element_value,
                  output ready);
endinterface

interface hdc_out_if;
  logic                           valid;
  logic                           ready;
  logic [hdc_pkg::BEST_W-1:0]     best_class;
  logic                           none_trained;

  modport source (output valid, output best_class, output none_trained, input ready);
  modport sink   (input valid, input best_class, input none_trained, output ready);
endinterface

>>> src/hdc_datapath.sv
module hdc_datapath #(
  parameter int CLASS_COUNT_MAX = hdc_pkg::DEF_CLASS_COUNT_MAX,
  parameter int DIMENSION_MAX   = hdc_pkg::DEF_DIMENSION_MAX,
  parameter int PROTO_WIDTH     = hdc_pkg::DEF_PROTO_WIDTH
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  hdc_pkg::cmd_t                              cmd_i,
  input  logic [$clog2(DIMENSION_MAX)-1:0]           addr_i,
  input  logic [$clog2(CLASS_COUNT_MAX)-1:0]         cls_i,
  input  logic signed [hdc_pkg::ELEM_W-1:0]          elem_i,
  input  logic                                       out_ready_i,
  output logic                                       out_valid_o,
  output logic [hdc_pkg::BEST_W-1:0]                 best_class_o,
  output logic                                       none_trained_o,
  output hdc_pkg::sts_t                              sts_o
);

  localparam int PW     = PROTO_WIDTH;
  localparam int POS_W  = $clog2(DIMENSION_MAX);
  localparam int CLS_W  = $clog2(CLASS_COUNT_MAX);
  localparam int ROW_W  = CLASS_COUNT_MAX * PW;
  localparam int DOT_W  = hdc_pkg::f_dot_w(PW, DIMENSION_MAX);
  localparam int NORM_W = hdc_pkg::f_norm_w(PW, DIMENSION_MAX);
  localparam int XW     = 2 * DOT_W + NORM_W;
  localparam int MW     = (DOT_W > NORM_W) ? DOT_W : NORM_W;
  localparam int PE_W   = PW + hdc_pkg::ELEM_W;
  localparam int PP_W   = 2 * PW;

  // prototype store: one row holds every class at one position
  logic [ROW_W-1:0] mem_q [DIMENSION_MAX];
  logic [ROW_W-1:0] row_q;
  logic [ROW_W-1:0] row_wr;
  logic [POS_W-1:0] addr_q;
  logic signed [hdc_pkg::ELEM_W-1:0] elem_q;

  logic signed [PW-1:0] proto_sel;
  logic signed [PW:0]   sum;
  logic signed [PW-1:0] sat;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem_q[addr_i] <= '0;
    end else if (cmd_i.tr_wr) begin
      mem_q[addr_q] <= row_wr;
    end
    if (cmd_i.rd_en) begin
      row_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      addr_q <= addr_i;
      elem_q <= elem_i;
    end
  end

  // saturating prototype update
  always_comb begin
    proto_sel = row_q[cls_i*PW +: PW];
    sum       = (PW+1)'(proto_sel) + (PW+1)'(elem_q);
    if (sum[PW] != sum[PW-1]) begin
      sat = sum[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end else begin
      sat = sum[PW-1:0];
    end
    row_wr = row_q;
    row_wr[cls_i*PW +: PW] = sat;
  end

  // products, one class per cycle
  logic signed [PE_W-1:0] pe_q;
  logic        [PP_W-1:0] pp_q;
  logic signed [PP_W-1:0] psq;
  logic [CLS_W-1:0]       prod_cls_q;
  logic                   prod_vld_q;

  assign psq = proto_sel * proto_sel;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_en) begin
      pe_q       <= proto_sel * elem_q;
      pp_q       <= unsigned'(psq);
      prod_cls_q <= cls_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mac_en;
    end
  end

  // per-class accumulators, single access index
  logic signed [DOT_W-1:0] dot_q  [CLASS_COUNT_MAX];
  logic        [NORM_W-1:0] norm_q [CLASS_COUNT_MAX];
  logic [CLS_W-1:0]         acc_idx;
  logic signed [DOT_W-1:0]  dot_rd;
  logic        [NORM_W-1:0] norm_rd;

  assign acc_idx = prod_vld_q ? prod_cls_q : cls_i;
  assign dot_rd  = dot_q[acc_idx];
  assign norm_rd = norm_q[acc_idx];

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      for (int i = 0; i < CLASS_COUNT_MAX; i++) begin
        dot_q[i]  <= '0;
        norm_q[i] <= '0;
      end
    end else if (prod_vld_q) begin
      dot_q[acc_idx]  <= dot_rd + DOT_W'(pe_q);
      norm_q[acc_idx] <= norm_rd + NORM_W'(pp_q);
    end
  end

  // running best
  logic [CLS_W-1:0]         best_idx_q;
  logic signed [DOT_W-1:0]  best_dot_q;
  logic        [NORM_W-1:0] best_norm_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.arg_init || cmd_i.best_upd) begin
      best_idx_q  <= cls_i;
      best_dot_q  <= dot_rd;
      best_norm_q <= norm_rd;
    end
  end

  // score signs: zero norm scores zero
  logic sc_pos, sc_neg, sb_pos, sb_neg;
  assign sc_neg = (norm_rd != '0) && dot_rd[DOT_W-1];
  assign sc_pos = (norm_rd != '0) && !dot_rd[DOT_W-1] && (dot_rd != '0);
  assign sb_neg = (best_norm_q != '0) && best_dot_q[DOT_W-1];
  assign sb_pos = (best_norm_q != '0) && !best_dot_q[DOT_W-1] && (best_dot_q != '0);

  // shift-add multiplier for dot^2 * norm
  logic [XW-1:0]           mcand_q, macc_q, left_q;
  logic [MW-1:0]           mplier_q;
  logic signed [DOT_W-1:0] dot_op;
  logic [DOT_W-1:0]        mag;
  logic [NORM_W-1:0]       norm_op;

  assign dot_op  = cmd_i.sel_right ? best_dot_q : dot_rd;
  assign mag     = dot_op[DOT_W-1] ? unsigned'(-dot_op) : unsigned'(dot_op);
  assign norm_op = cmd_i.sel_right ? norm_rd : best_norm_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.mul_op)
      hdc_pkg::MUL_LOAD_SQ: begin
        mcand_q  <= XW'(mag);
        mplier_q <= MW'(mag);
        macc_q   <= '0;
      end
      hdc_pkg::MUL_LOAD_NM: begin
        mcand_q  <= macc_q;
        mplier_q <= MW'(norm_op);
        macc_q   <= '0;
      end
      hdc_pkg::MUL_STEP: begin
        if (mplier_q[0]) begin
          macc_q <= macc_q + mcand_q;
        end
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
      end
      hdc_pkg::MUL_SAVE: begin
        left_q <= macc_q;
      end
      default: begin
      end
    endcase
  end

  logic mul_beats, direct_beats;
  assign mul_beats    = sc_pos ? (left_q > macc_q) : (left_q < macc_q);
  assign direct_beats = (sc_pos && !sb_pos) || (!sc_pos && !sc_neg && sb_neg);

  // result register
  logic                        out_valid_q;
  logic [hdc_pkg::BEST_W-1:0]  best_out_q;
  logic                        none_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      best_out_q <= cmd_i.res_none ? '0 : hdc_pkg::BEST_W'(best_idx_q);
      none_out_q <= cmd_i.res_none;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign best_class_o   = best_out_q;
  assign none_trained_o = none_out_q;

  assign sts_o.need_mul = (sc_pos && sb_pos) || (sc_neg && sb_neg);
  assign sts_o.beats    = sts_o.need_mul ? mul_beats : direct_beats;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

>>> src/hdc_ctrl.sv
module hdc_ctrl #(
  parameter int CLASS_COUNT_MAX = hdc_pkg::DEF_CLASS_COUNT_MAX,
  parameter int DIMENSION_MAX   = hdc_pkg::DEF_DIMENSION_MAX,
  parameter int PROTO_WIDTH     = hdc_pkg::DEF_PROTO_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hdc_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  input  logic [hdc_pkg::OP_W-1:0]            in_opcode_i,
  input  logic [hdc_pkg::CLS_IN_W-1:0]        in_class_i,
  output logic                                in_ready_o,
  input  hdc_pkg::sts_t                       sts_i,
  output hdc_pkg::cmd_t                       cmd_o,
  output logic [$clog2(DIMENSION_MAX)-1:0]    addr_o,
  output logic [$clog2(CLASS_COUNT_MAX)-1:0]  cls_o
);

  localparam int POS_W   = $clog2(DIMENSION_MAX);
  localparam int CLS_W   = $clog2(CLASS_COUNT_MAX);
  localparam int TR_W    = $clog2(CLASS_COUNT_MAX + 1);
  localparam int LEN_W   = $clog2(DIMENSION_MAX + 1);
  localparam int DOT_W   = hdc_pkg::f_dot_w(PROTO_WIDTH, DIMENSION_MAX);
  localparam int NORM_W  = hdc_pkg::f_norm_w(PROTO_WIDTH, DIMENSION_MAX);
  localparam int CM_A    = (DIMENSION_MAX - 1 > CLASS_COUNT_MAX) ? DIMENSION_MAX - 1
                                                                 : CLASS_COUNT_MAX;
  localparam int CM_B    = (DOT_W > NORM_W) ? DOT_W : NORM_W;
  localparam int CNT_MAX = (CM_A > CM_B) ? CM_A : CM_B;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'h0001,
    S_IDLE     = 13'h0002,
    S_TRAIN    = 13'h0004,
    S_MAC      = 13'h0008,
    S_ARG_INIT = 13'h0010,
    S_ARG_CMP  = 13'h0020,
    S_SQ_LOAD  = 13'h0040,
    S_SQ_STEP  = 13'h0080,
    S_NM_LOAD  = 13'h0100,
    S_NM_STEP  = 13'h0200,
    S_SAVE     = 13'h0400,
    S_DECIDE   = 13'h0800,
    S_RESULT   = 13'h1000
  } state_e;

  state_e                        state_q, state_d;
  logic [hdc_pkg::CFG_W-1:0]     len_q;
  logic [POS_W-1:0]              pos_q, pos_d;
  logic [hdc_pkg::OP_W-1:0]      lop_q, lop_d;
  logic [hdc_pkg::CLS_IN_W-1:0]  lcls_q, lcls_d;
  logic [TR_W-1:0]               trained_q, trained_d;
  logic                          last_q, last_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [TR_W-1:0]               cls_q, cls_d;
  logic                          side_q, side_d;

  logic [LEN_W-1:0]              len_eff;
  logic                          first, last;
  logic [hdc_pkg::OP_W-1:0]      op_eff;
  logic [hdc_pkg::CLS_IN_W-1:0]  cls_eff;
  logic                          cls_eff_ok, lcls_ok;

  always_comb begin
    if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(len_q) > DIMENSION_MAX) begin
      len_eff = LEN_W'(DIMENSION_MAX);
    end else begin
      len_eff = LEN_W'(len_q);
    end
  end

  assign first      = (pos_q == '0);
  assign last       = (LEN_W'(pos_q) + LEN_W'(1)) >= len_eff;
  assign op_eff     = first ? in_opcode_i : lop_q;
  assign cls_eff    = first ? in_class_i : lcls_q;
  assign cls_eff_ok = 32'(cls_eff) < CLASS_COUNT_MAX;
  assign lcls_ok    = 32'(lcls_q) < CLASS_COUNT_MAX;

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    lop_d      = lop_q;
    lcls_d     = lcls_q;
    trained_d  = trained_q;
    last_d     = last_q;
    cnt_d      = cnt_q;
    cls_d      = cls_q;
    side_d     = side_q;
    cmd_o        = '0;
    cmd_o.mul_op = hdc_pkg::MUL_IDLE;
    addr_o     = pos_q;
    cls_o      = CLS_W'(cls_q);
    in_ready_o = 1'b0;

    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        addr_o       = cnt_q[POS_W-1:0];
        if (cnt_q == CNT_W'(DIMENSION_MAX - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (first && in_opcode_i == hdc_pkg::OP_CLEAR) begin
            trained_d = '0;
            cnt_d     = '0;
            state_d   = S_CLEAR;
          end else if (!first || in_opcode_i == hdc_pkg::OP_TRAIN ||
                       in_opcode_i == hdc_pkg::OP_CLASSIFY) begin
            if (first) begin
              lop_d  = in_opcode_i;
              lcls_d = in_class_i;
            end
            cmd_o.rd_en = 1'b1;
            last_d      = last;
            pos_d       = last ? '0 : pos_q + POS_W'(1);
            if (op_eff == hdc_pkg::OP_TRAIN) begin
              state_d = S_TRAIN;
              if (last && cls_eff_ok &&
                  (TR_W'(cls_eff) + TR_W'(1)) > trained_q) begin
                trained_d = TR_W'(cls_eff) + TR_W'(1);
              end
            end else begin
              cmd_o.acc_clr = first;
              cnt_d         = '0;
              state_d       = S_MAC;
            end
          end
        end
      end

      S_TRAIN: begin
        cls_o       = CLS_W'(lcls_q);
        cmd_o.tr_wr = lcls_ok;
        state_d     = S_IDLE;
      end

      S_MAC: begin
        cls_o = CLS_W'(cnt_q);
        if (cnt_q < CNT_W'(CLASS_COUNT_MAX)) begin
          cmd_o.mac_en = 1'b1;
          cnt_d        = cnt_q + CNT_W'(1);
        end else begin
          // drain: last product lands in its accumulator
          cnt_d = '0;
          if (!last_q) begin
            state_d = S_IDLE;
          end else if (trained_q == '0) begin
            state_d = S_RESULT;
          end else begin
            state_d = S_ARG_INIT;
          end
        end
      end

      S_ARG_INIT: begin
        cls_o          = '0;
        cmd_o.arg_init = 1'b1;
        cls_d          = TR_W'(1);
        state_d        = S_ARG_CMP;
      end

      S_ARG_CMP: begin
        if (cls_q >= trained_q) begin
          state_d = S_RESULT;
        end else if (sts_i.need_mul) begin
          side_d  = 1'b0;
          state_d = S_SQ_LOAD;
        end else begin
          cmd_o.best_upd = sts_i.beats;
          cls_d          = cls_q + TR_W'(1);
        end
      end

      S_SQ_LOAD: begin
        cmd_o.mul_op    = hdc_pkg::MUL_LOAD_SQ;
        cmd_o.sel_right = side_q;
        cnt_d           = '0;
        state_d         = S_SQ_STEP;
      end

      S_SQ_STEP: begin
        cmd_o.mul_op = hdc_pkg::MUL_STEP;
        if (cnt_q == CNT_W'(DOT_W - 1)) begin
          cnt_d   = '0;
          state_d = S_NM_LOAD;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      S_NM_LOAD: begin
        cmd_o.mul_op    = hdc_pkg::MUL_LOAD_NM;
        cmd_o.sel_right = side_q;
        cnt_d           = '0;
        state_d         = S_NM_STEP;
      end

      S_NM_STEP: begin
        cmd_o.mul_op = hdc_pkg::MUL_STEP;
        if (cnt_q == CNT_W'(NORM_W - 1)) begin
          cnt_d   = '0;
          state_d = side_q ? S_DECIDE : S_SAVE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      S_SAVE: begin
        cmd_o.mul_op = hdc_pkg::MUL_SAVE;
        side_d       = 1'b1;
        state_d      = S_SQ_LOAD;
      end

      S_DECIDE: begin
        cmd_o.best_upd = sts_i.beats;
        cls_d          = cls_q + TR_W'(1);
        state_d        = S_ARG_CMP;
      end

      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_none = (trained_q == '0);
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      len_q     <= hdc_pkg::LEN_RST;
      pos_q     <= '0;
      lop_q     <= hdc_pkg::OP_TRAIN;
      lcls_q    <= '0;
      trained_q <= '0;
      last_q    <= 1'b0;
      cnt_q     <= '0;
      cls_q     <= '0;
      side_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
      pos_q     <= pos_d;
      lop_q     <= lop_d;
      lcls_q    <= lcls_d;
      trained_q <= trained_d;
      last_q    <= last_d;
      cnt_q     <= cnt_d;
      cls_q     <= cls_d;
      side_q    <= side_d;
    end
  end

endmodule

>>> src/hdc_prototype_classifier_top.sv
// Train word: accepted in S_IDLE, then the prototype row is written back in S_TRAIN.
// Classify word: accepted, then S_MAC does one shared multiply-accumulate per class and drains the last product.
// Last classify word adds the argmax: each class below the trained count whose score sign
// ties the running best goes through the bit-serial cross-multiplier; others compare by sign.
// Reset and clear sweep the prototype store, one row per cycle, over all DIMENSION_MAX rows;
// no word is accepted during the sweep, the length register is always writable.
module hdc_prototype_classifier_top #(
  parameter int CLASS_COUNT_MAX = hdc_pkg::DEF_CLASS_COUNT_MAX,
  parameter int DIMENSION_MAX   = hdc_pkg::DEF_DIMENSION_MAX,
  parameter int PROTO_WIDTH     = hdc_pkg::DEF_PROTO_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hdc_pkg::CFG_W-1:0] cfg_data_i,
  hdc_in_if.sink                    in_i,
  hdc_out_if.source                 out_o
);

  // Controller owns the vector position, latched opcode/class, trained count and
  // the length register; datapath owns the store, accumulators and multiplier.
  hdc_pkg::cmd_t                        cmd;
  hdc_pkg::sts_t                        sts;
  logic [$clog2(DIMENSION_MAX)-1:0]     addr;
  logic [$clog2(CLASS_COUNT_MAX)-1:0]   cls;

  hdc_ctrl #(
    .CLASS_COUNT_MAX (CLASS_COUNT_MAX),
    .DIMENSION_MAX   (DIMENSION_MAX),
    .PROTO_WIDTH     (PROTO_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_class_i  (in_i.class_index),
    .in_ready_o  (in_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .addr_o      (addr),
    .cls_o       (cls)
  );

  // Result sits in an output register, so a new word is taken while it waits.
  hdc_datapath #(
    .CLASS_COUNT_MAX (CLASS_COUNT_MAX),
    .DIMENSION_MAX   (DIMENSION_MAX),
    .PROTO_WIDTH     (PROTO_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .addr_i         (addr),
    .cls_i          (cls),
    .elem_i         (in_i.element_value),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .best_class_o   (out_o.best_class),
    .none_trained_o (out_o.none_trained),
    .sts_o          (sts)
  );

endmodule
